// ===== sv/ism_pkg.sv =====
// Shared constants, types and codes of the interval subscription matcher.
`default_nettype none
package ism_pkg;

	// sizing
	localparam int SUBS       = 1024;
	localparam int ATTS       = 32;
	localparam int VALUE_BITS = 20;
	localparam int SUB_W      = $clog2(SUBS);
	localparam int ATT_W      = 5;
	localparam int CNT_W      = 11;

	localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SUBS - 1);

	// item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_PAIR   = 1'b1;

	// one stored interval constraint
	typedef struct packed {
		logic                  present;
		logic [VALUE_BITS-1:0] low;
		logic [VALUE_BITS-1:0] high;
	} entry_t;

	// token handed from cell to cell: one subscription slot and its fail flag
	typedef struct packed {
		logic             valid;
		logic [SUB_W-1:0] sub;
		logic             fail;
	} tok_t;

	// per-cell control
	typedef struct packed {
		logic wr_en;
		logic chk;
		logic miss;
	} cell_ctl_t;

	// signals common to every cell
	typedef struct packed {
		logic [SUB_W-1:0]      wr_sub;
		entry_t                wr_entry;
		logic [VALUE_BITS-1:0] value;
	} shared_t;

endpackage
`default_nettype wire

// ===== sv/ism_ifs.sv =====
// Valid/ready channel interfaces for input items and match results.
`default_nettype none
interface ism_item_if;
	import ism_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [SUB_W-1:0]      sub_id;
	logic [ATT_W-1:0]      attribute;
	logic [VALUE_BITS-1:0] low_value;
	logic [VALUE_BITS-1:0] high_value;
	logic [VALUE_BITS-1:0] pub_value;
	logic                  last_pair;

	modport source (output valid, kind, sub_id, attribute, low_value, high_value,
		pub_value, last_pair, input ready);
	modport sink (input valid, kind, sub_id, attribute, low_value, high_value,
		pub_value, last_pair, output ready);
endinterface

interface ism_result_if;
	import ism_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] match_count;

	modport source (output valid, match_count, input ready);
	modport sink (input valid, match_count, output ready);
endinterface
`default_nettype wire

// ===== sv/ism_cell.sv =====
// One attribute cell: holds that attribute's interval of every slot, checks passing tokens.
`default_nettype none
module ism_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ism_pkg::cell_ctl_t ctl,
	input  ism_pkg::shared_t  shr,
	input  ism_pkg::tok_t     tok_in,
	output ism_pkg::tok_t     tok_out
);
	import ism_pkg::*;

	entry_t entry_q [SUBS];
	entry_t rd_q;
	tok_t   tok_s1;
	tok_t   tok_s2;
	logic   outside;
	logic   hit;

	// interval store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			entry_q[shr.wr_sub] <= shr.wr_entry;
		rd_q <= entry_q[tok_in.sub];
	end

	// slot fails here on a value outside the interval, or on an unnamed attribute
	assign outside = (shr.value < rd_q.low) || (shr.value > rd_q.high);
	assign hit     = rd_q.present && ((ctl.chk && outside) || ctl.miss);

	// two token stages, aligned with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= '{valid: tok_s1.valid, sub: tok_s1.sub, fail: tok_s1.fail | hit};
		end
	end

	assign tok_out = tok_s2;

endmodule
`default_nettype wire

// ===== sv/interval_subscription_matcher.sv =====
// Interval subscription matcher: chain of attribute cells with sweep control.
//
// Channels: items (sink) takes inserts and publication pairs, results (source)
// gives one match_count after the pair marked last_pair. Both are valid/ready;
// a transfer happens on a clock edge with valid and ready high.
// An insert writes the interval into the cell of its attribute. A publication
// pair sweeps every subscription slot through the row of ATTS cells, one slot
// entering per cycle; each cell adds two stages. Once the sweep of the last
// pair drains, the result is loaded as soon as the result register is free.
// Items are taken only between sweeps: one insert per cycle while idle, and a
// new pair only after the previous sweep is through.
// After reset a clearing pass over all SUBS slots empties the constraint and
// fail stores; items.ready stays low meanwhile.
// A result waiting on a stalled receiver does not block new items; only a
// further result waits until the earlier one has been taken.
`default_nettype none
module interval_subscription_matcher (
	input  logic         clk,
	input  logic         arst_n,
	ism_item_if.sink     items,
	ism_result_if.source results
);
	import ism_pkg::*;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SWEEP, ST_RESULT} state_t;

	state_t                state_q;
	logic [SUB_W-1:0]      clr_q;
	logic [SUB_W-1:0]      iss_q;
	logic                  issuing_q;
	logic                  head_valid_q;
	logic [SUB_W-1:0]      head_sub_q;
	logic                  flag_rd_q;
	logic                  flag_q [SUBS];
	logic [ATT_W-1:0]      att_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  chk_q;
	logic                  fin_q;
	logic [ATTS-1:0]       seen_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  res_valid_q;
	logic [CNT_W-1:0]      res_count_q;

	tok_t      chain [ATTS+1];
	cell_ctl_t ctl [ATTS];
	shared_t   shr;
	logic      accept;
	logic      att_ok;
	logic      ins_fire;
	logic      tail_done;
	logic      res_load;

	assign accept   = items.valid && items.ready;
	assign att_ok   = int'(items.attribute) < ATTS;
	assign ins_fire = accept && (items.kind == KIND_INSERT) && att_ok &&
		(int'(items.sub_id) < SUBS);

	assign items.ready       = (state_q == ST_IDLE);
	assign results.valid       = res_valid_q;
	assign results.match_count = res_count_q;

	assign tail_done = chain[ATTS].valid && (chain[ATTS].sub == SUB_LAST);
	assign res_load  = (state_q == ST_RESULT) && (!res_valid_q || results.ready);

	// common write data: zero during the clearing pass, else the insert
	always_comb begin
		shr.value = value_q;
		if (state_q == ST_CLEAR) begin
			shr.wr_sub   = clr_q;
			shr.wr_entry = '0;
		end else begin
			shr.wr_sub   = items.sub_id;
			shr.wr_entry = '{present: 1'b1, low: items.low_value, high: items.high_value};
		end
	end

	// head of the chain: slot index plus its fail flag so far
	assign chain[0] = '{valid: head_valid_q, sub: head_sub_q, fail: flag_rd_q};

	// row of attribute cells
	for (genvar a = 0; a < ATTS; a++) begin : g_cell
		assign ctl[a].wr_en = (state_q == ST_CLEAR) ||
			(ins_fire && (items.attribute == ATT_W'(a)));
		assign ctl[a].chk   = chk_q && (att_q == ATT_W'(a));
		assign ctl[a].miss  = fin_q && !seen_q[a];

		ism_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[a]),
			.shr     (shr),
			.tok_in  (chain[a]),
			.tok_out (chain[a+1])
		);
	end

	// per-slot fail flags: read at issue, written back at the tail
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			flag_q[clr_q] <= 1'b0;
		else if (chain[ATTS].valid)
			flag_q[chain[ATTS].sub] <= chain[ATTS].fail & ~fin_q;
		flag_rd_q <= flag_q[iss_q];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load)
			res_count_q <= cnt_q;
	end

	// sequencer: clearing pass, item intake, sweep issue, result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			iss_q        <= '0;
			issuing_q    <= 1'b0;
			head_valid_q <= 1'b0;
			head_sub_q   <= '0;
			att_q        <= '0;
			value_q      <= '0;
			chk_q        <= 1'b0;
			fin_q        <= 1'b0;
			seen_q       <= '0;
			cnt_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			head_valid_q <= issuing_q;
			head_sub_q   <= iss_q;
			// result valid: set on load, cleared on transfer
			if (res_load)
				res_valid_q <= 1'b1;
			else if (results.valid && results.ready)
				res_valid_q <= 1'b0;
			if (chain[ATTS].valid && !chain[ATTS].fail)
				cnt_q <= cnt_q + 1'b1;

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SUB_LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && (items.kind == KIND_PAIR)) begin
						if (att_ok)
							seen_q[items.attribute] <= 1'b1;
						att_q     <= items.attribute;
						value_q   <= items.pub_value;
						chk_q     <= att_ok;
						fin_q     <= items.last_pair;
						cnt_q     <= '0;
						iss_q     <= '0;
						issuing_q <= 1'b1;
						state_q   <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (issuing_q) begin
						iss_q <= iss_q + 1'b1;
						if (iss_q == SUB_LAST)
							issuing_q <= 1'b0;
					end
					if (tail_done) begin
						chk_q <= 1'b0;
						if (fin_q) begin
							seen_q  <= '0;
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RESULT: begin
					if (res_load) begin
						fin_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
